// ----- sv/hsec_pkg.sv -----
package hsec_pkg;

	// field widths
	localparam int MAX_DATA_BITS = 57;
	localparam int DATA_W        = MAX_DATA_BITS;
	localparam int WORD_W        = 63;
	localparam int SYN_W         = 6;
	localparam int CFG_W         = 6;
	localparam int PAR_W         = 3;
	localparam int NUM_GROUPS    = SYN_W;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

	// request codes
	localparam logic REQ_ENCODE = 1'b0;
	localparam logic REQ_CHECK  = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CORRECTED = 2'd1;
	localparam logic [1:0] ST_BEYOND    = 2'd2;

	typedef struct packed {
		logic              req_type;
		logic [DATA_W-1:0] data_word;
		logic [WORD_W-1:0] received_word;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_word;
		logic [SYN_W-1:0]  syndrome;
		logic [1:0]        status;
	} rsp_t;

	// clamp the configured data bit count into 1..MAX_DATA_BITS
	function automatic logic [CFG_W-1:0] eff_m(logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] m;
		m = v;
		if (v == '0)
			m = CFG_W'(1);
		else if (v > CFG_W'(MAX_DATA_BITS))
			m = CFG_W'(MAX_DATA_BITS);
		return m;
	endfunction

	// least r >= 2 with 2^r >= m + r + 1
	function automatic logic [PAR_W-1:0] parity_count(logic [CFG_W-1:0] m);
		logic [PAR_W-1:0] r;
		if (m <= CFG_W'(1))
			r = PAR_W'(2);
		else if (m <= CFG_W'(4))
			r = PAR_W'(3);
		else if (m <= CFG_W'(11))
			r = PAR_W'(4);
		else if (m <= CFG_W'(26))
			r = PAR_W'(5);
		else
			r = PAR_W'(6);
		return r;
	endfunction

	// codeword length n = m + r, at most 63
	function automatic logic [SYN_W-1:0] code_len(logic [CFG_W-1:0] m);
		return SYN_W'(m) + SYN_W'(parity_count(m));
	endfunction

	// positions whose index has bit i set
	function automatic logic [WORD_W-1:0] group_mask(int i);
		logic [WORD_W-1:0] mask;
		mask = '0;
		for (int k = 0; k < WORD_W; k++)
			mask[k] = 1'(((k + 1) >> i) & 1);
		return mask;
	endfunction

endpackage

// ----- sv/hsec_codec.sv -----
module hsec_codec (
	input  hsec_pkg::req_t                   req,
	input  logic [hsec_pkg::CFG_W-1:0]       m,
	input  logic [hsec_pkg::SYN_W-1:0]       n,
	output hsec_pkg::rsp_t                   rsp
);

	logic [hsec_pkg::DATA_W-1:0]     msg;
	logic [hsec_pkg::WORD_W-1:0]     spread;
	logic [hsec_pkg::WORD_W-1:0]     len_mask;
	logic [hsec_pkg::WORD_W-1:0]     rx_word;
	logic [hsec_pkg::WORD_W-1:0]     enc_word;
	logic [hsec_pkg::WORD_W-1:0]     flip;
	logic [hsec_pkg::SYN_W-1:0]      enc_par;
	logic [hsec_pkg::SYN_W-1:0]      syn;
	logic [hsec_pkg::SYN_W-1:0]      syn_idx;

	// keep only the data bits in use
	always_comb begin
		for (int x = 0; x < hsec_pkg::DATA_W; x++)
			msg[x] = req.data_word[x] & (hsec_pkg::CFG_W'(x) < m);
	end

	// data bits fill the non power of two positions in order
	for (genvar k = 0; k < hsec_pkg::WORD_W; k++) begin : g_spread
		localparam int POS = k + 1;
		localparam int IDX = POS - 1 - $clog2(POS + 1);
		if ((POS & (POS - 1)) != 0) begin : g_data
			assign spread[k] = msg[IDX];
		end else begin : g_par
			assign spread[k] = 1'b0;
		end
	end

	// codeword length mask
	always_comb begin
		for (int k = 0; k < hsec_pkg::WORD_W; k++)
			len_mask[k] = (hsec_pkg::SYN_W'(k) < n);
	end

	assign rx_word = req.received_word & len_mask;

	// group parities for encode and syndrome
	always_comb begin
		for (int i = 0; i < hsec_pkg::NUM_GROUPS; i++) begin
			enc_par[i] = ^(spread & hsec_pkg::group_mask(i));
			syn[i]     = ^(rx_word & hsec_pkg::group_mask(i));
		end
	end

	// parity bits go to the power of two positions
	always_comb begin
		enc_word = spread;
		for (int i = 0; i < hsec_pkg::NUM_GROUPS; i++)
			enc_word[(1 << i) - 1] = enc_par[i];
	end

	assign syn_idx = syn - hsec_pkg::SYN_W'(1);
	assign flip    = hsec_pkg::WORD_W'(1) << syn_idx;

	// result select
	always_comb begin
		rsp.result_word = enc_word;
		rsp.syndrome    = '0;
		rsp.status      = hsec_pkg::ST_OK;
		if (req.req_type == hsec_pkg::REQ_CHECK) begin
			rsp.result_word = rx_word;
			rsp.syndrome    = syn;
			if (syn != '0) begin
				if (syn <= n) begin
					rsp.result_word = rx_word ^ flip;
					rsp.status      = hsec_pkg::ST_CORRECTED;
				end else begin
					rsp.status      = hsec_pkg::ST_BEYOND;
				end
			end
		end
	end

endmodule

// ----- sv/hamming_sec_encode_check_core.sv -----
// Hamming single error correcting codec, even parity, m data bits (1..57).
// Input: pulse start with a request on req; busy is always low, so a request
// is taken at every clock edge where start is high, one per cycle.
// req_type selects encode (data_word -> codeword) or check (received_word
// -> syndrome, corrected word and status).
// Output: done is high for exactly one cycle with the result on rsp; the
// receiver must take it then, there is no back pressure.
// Pipeline: the request is captured in the input register, passes the parity
// trees and the result goes into the result register, which drives rsp and
// done. Throughput is one item per cycle, set by the single pass of XOR
// trees between the two registers.
// Configuration: cfg_we writes cfg_wdata into the data bit count; write it
// only with no request in flight. Values 0 and above 57 act as 1 and 57.
// Reset: arst_n clears the valid bits of both pipeline stages and sets the
// data bit count to 4 (a 7 bit codeword). Check status: 0 clean, 1 corrected,
// 2 syndrome beyond the codeword length (word returned unchanged).
module hamming_sec_encode_check_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  hsec_pkg::req_t              req,
	output logic                        done,
	output hsec_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [hsec_pkg::CFG_W-1:0]  cfg_wdata
);

	logic [hsec_pkg::CFG_W-1:0] data_bits_q;
	logic [hsec_pkg::CFG_W-1:0] m;
	logic [hsec_pkg::SYN_W-1:0] n;
	logic                       valid_s1;
	hsec_pkg::req_t             req_s1;
	logic                       valid_s2;
	hsec_pkg::rsp_t             rsp_s2;
	hsec_pkg::rsp_t             rsp_comb;

	assign busy = 1'b0;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			data_bits_q <= hsec_pkg::CFG_RESET;
		else if (cfg_we)
			data_bits_q <= cfg_wdata;
	end

	assign m = hsec_pkg::eff_m(data_bits_q);
	assign n = hsec_pkg::code_len(m);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	// input register on every transfer
	always_ff @(posedge clk) begin
		if (start && !busy)
			req_s1 <= req;
	end

	hsec_codec u_codec (
		.req (req_s1),
		.m   (m),
		.n   (n),
		.rsp (rsp_comb)
	);

	// result register
	always_ff @(posedge clk) begin
		if (valid_s1)
			rsp_s2 <= rsp_comb;
	end

	assign done = valid_s2;
	assign rsp  = rsp_s2;

	// every accepted request is followed by a result strobe on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("result strobe missing after request");

	// clean status exactly when the syndrome is zero
	a_status_syn: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.syndrome == '0) == (rsp.status == hsec_pkg::ST_OK)))
		else $error("status disagrees with syndrome");

	// out of range status only when the syndrome exceeds the codeword length
	a_beyond: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((rsp.status == hsec_pkg::ST_BEYOND) == (rsp.syndrome > n)))
		else $error("beyond status inconsistent with codeword length");

endmodule
